### hw/rtl/rlff_pkg.sv
package rlff_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SUM_W   = 2 * DIFF_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int TRIAL_W = SUM_W + 2;
    localparam int GAIN_W  = 32;
    localparam int ZD_W    = 31;
    localparam int OUT_W   = 31;
    localparam int DEPTH_W = 32;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int LANES   = 5;
    localparam int PROD_W  = GAIN_W + ROOT_W;
    localparam int DIV_STEPS = OUT_W;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;
    localparam logic [ZD_W-1:0] ZD_RESET = ZD_W'(65536);
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [IDX_W-1:0] REG_MODE     = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_CENTER_Z = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_ZERO_DIST = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_GAINS_UV = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_GAINS_TS = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_GAIN_DYE = IDX_W'(7);

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_height;
    } query_t;

    typedef struct packed {
        logic [OUT_W-1:0]          vel_u;
        logic [OUT_W-1:0]          vel_v;
        logic [OUT_W-1:0]          temperature;
        logic [OUT_W-1:0]          salinity;
        logic [OUT_W-1:0]          dye_level;
        logic signed [DEPTH_W-1:0] depth_out;
    } sample_t;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [ZD_W-1:0]           zero_distance;
        logic [LANES-1:0][GAIN_W-1:0] gains;
        logic signed [DEPTH_W-1:0] depth;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [SUM_W-1:0]  sum_sq;
        logic [DIFF_W-1:0] cheb;
    } request_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic empty;
        logic full;
    } q_ctl_t;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

### hw/rtl/rlff_front.sv
module rlff_front
    import rlff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid,
    input  query_t   query,
    input  cfg_t     cfg,
    output logic     out_valid,
    output request_t request
);

    logic [2:0]        v_reg;
    logic [DIFF_W-1:0] ax_reg, ay_reg, az_reg;
    logic              m1_reg, m2_reg, m3_reg;
    logic [SUM_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [DIFF_W-1:0] ch2_reg, ch3_reg;
    logic [SUM_W-1:0]  sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= abs_diff(query.pos_x, cfg.center_x);
            ay_reg  <= abs_diff(query.pos_y, cfg.center_y);
            az_reg  <= abs_diff(query.pos_height, cfg.center_z);
            m1_reg  <= cfg.mode;
            sx_reg  <= ax_reg * ax_reg;
            sy_reg  <= ay_reg * ay_reg;
            sz_reg  <= az_reg * az_reg;
            ch2_reg <= (ax_reg > ay_reg) ? ax_reg : ay_reg;
            m2_reg  <= m1_reg;
            sum_reg <= sx_reg + sy_reg + sz_reg;
            ch3_reg <= ch2_reg;
            m3_reg  <= m2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign request   = '{mode: m3_reg, sum_sq: sum_reg, cheb: ch3_reg};

endmodule

### hw/rtl/rlff_queue.sv
module rlff_queue
    import rlff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_ctl_t   ctl_in,
    input  request_t push_data,
    output q_ctl_t   ctl_out,
    output request_t head
);

    request_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, rd_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign ctl_out.push  = ctl_in.push;
    assign ctl_out.pop   = ctl_in.pop;
    assign ctl_out.empty = (cnt_reg == '0);
    assign ctl_out.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl_in.push && !ctl_in.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!ctl_in.push && ctl_in.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctl_in.push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (ctl_in.pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.full |-> !ctl_in.push || ctl_in.pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.empty |-> !ctl_in.pop)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.push && !ctl_in.pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

### hw/rtl/rlff_back.sv
module rlff_back
    import rlff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  request_t request,
    input  cfg_t     cfg,
    output logic     out_valid,
    output sample_t  sample
);

    // square root: one root bit per stage
    logic               sv_reg   [ROOT_W];
    logic [SUM_W-1:0]   srem_reg [ROOT_W];
    logic [ROOT_W-1:0]  sroot_reg[ROOT_W];
    logic               smode_reg[ROOT_W];
    logic [DIFF_W-1:0]  sch_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic              v_in, m_in;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [DIFF_W-1:0] ch_in;
        logic [TRIAL_W-1:0] trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = request.sum_sq;
            assign root_in = '0;
            assign m_in    = request.mode;
            assign ch_in   = request.cheb;
        end
        else
        begin : g_next
            assign v_in    = sv_reg[k-1];
            assign rem_in  = srem_reg[k-1];
            assign root_in = sroot_reg[k-1];
            assign m_in    = smode_reg[k-1];
            assign ch_in   = sch_reg[k-1];
        end

        assign trial = (TRIAL_W'(root_in) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
        assign take  = (TRIAL_W'(rem_in) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[k]  <= take ? SUM_W'(TRIAL_W'(rem_in) - trial) : rem_in;
                sroot_reg[k] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
                smode_reg[k] <= m_in;
                sch_reg[k]   <= ch_in;
            end
        end
    end

    // distance difference, products, overflow check
    logic                   dv_reg, mv_reg, ov_reg;
    logic [ROOT_W-1:0]      dmag_reg;
    logic                   dneg_reg, dzero_reg;
    logic signed [ROOT_W:0] diff;
    logic [ROOT_W-1:0]      distance;
    logic [LANES-1:0]       mzero_reg, ozero_reg, osat_reg;
    logic [PROD_W-1:0]      prod_reg [LANES];
    logic [ZD_W-1:0]        orem_reg [LANES];
    logic [OUT_W-1:0]       olow_reg [LANES];

    assign distance = smode_reg[ROOT_W-1] ? ROOT_W'(sch_reg[ROOT_W-1]) : sroot_reg[ROOT_W-1];
    assign diff = $signed({3'b000, cfg.zero_distance}) - $signed({1'b0, distance});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg <= sv_reg[ROOT_W-1];
            mv_reg <= dv_reg;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg  <= diff[ROOT_W] ? ROOT_W'(-diff) : ROOT_W'(diff);
            dneg_reg  <= diff[ROOT_W];
            dzero_reg <= (diff == '0) || (cfg.zero_distance == '0);
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [GAIN_W-1:0] g;
        logic [GAIN_W-1:0]        gmag;
        logic [PROD_W-ZD_W-1:0]   top;

        assign g    = $signed(cfg.gains[l]);
        assign gmag = g[GAIN_W-1] ? GAIN_W'(-g) : GAIN_W'(g);
        assign top  = prod_reg[l][PROD_W-1:OUT_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[l]  <= gmag * dmag_reg;
                mzero_reg[l] <= dzero_reg || (g == '0) || (g[GAIN_W-1] != dneg_reg);
                osat_reg[l]  <= (top >= (PROD_W - ZD_W)'(cfg.zero_distance));
                orem_reg[l]  <= top[ZD_W-1:0];
                olow_reg[l]  <= prod_reg[l][OUT_W-1:0];
                ozero_reg[l] <= mzero_reg[l];
            end
        end
    end

    // restoring division: one quotient bit per stage
    logic             qv_reg   [DIV_STEPS];
    logic [ZD_W-1:0]  qrem_reg [DIV_STEPS][LANES];
    logic [OUT_W-1:0] qlow_reg [DIV_STEPS][LANES];
    logic [OUT_W-1:0] quo_reg  [DIV_STEPS][LANES];
    logic [LANES-1:0] qsat_reg [DIV_STEPS];
    logic [LANES-1:0] qzero_reg[DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic             v_in;
        logic [ZD_W-1:0]  rem_in [LANES];
        logic [OUT_W-1:0] low_in [LANES];
        logic [OUT_W-1:0] quo_in [LANES];
        logic [LANES-1:0] sat_in, zero_in;

        if (j == 0)
        begin : g_first
            assign v_in    = ov_reg;
            assign rem_in  = orem_reg;
            assign low_in  = olow_reg;
            assign quo_in  = '{default: '0};
            assign sat_in  = osat_reg;
            assign zero_in = ozero_reg;
        end
        else
        begin : g_next
            assign v_in    = qv_reg[j-1];
            assign rem_in  = qrem_reg[j-1];
            assign low_in  = qlow_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign sat_in  = qsat_reg[j-1];
            assign zero_in = qzero_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                qv_reg[j] <= v_in;
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_dl
            logic [ZD_W:0] t;
            logic          ge;

            assign t  = {rem_in[l], low_in[l][OUT_W-1]};
            assign ge = (t >= {1'b0, cfg.zero_distance});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    qrem_reg[j][l] <= ge ? ZD_W'(t - {1'b0, cfg.zero_distance}) : ZD_W'(t);
                    qlow_reg[j][l] <= low_in[l] << 1;
                    quo_reg[j][l]  <= {quo_in[l][OUT_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qsat_reg[j]  <= sat_in;
                qzero_reg[j] <= zero_in;
            end
        end
    end

    // result register
    logic                 rv_reg;
    logic [OUT_W-1:0]     res_reg [LANES];
    logic [DEPTH_W-1:0]   depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg <= qv_reg[DIV_STEPS-1];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_res
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[l] <= qzero_reg[DIV_STEPS-1][l] ? '0 :
                              qsat_reg[DIV_STEPS-1][l]  ? OUT_MAX :
                              quo_reg[DIV_STEPS-1][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            depth_reg <= cfg.depth;
        end
    end

    assign out_valid = rv_reg;
    assign sample = '{vel_u: res_reg[0], vel_v: res_reg[1], temperature: res_reg[2],
                      salinity: res_reg[3], dye_level: res_reg[4],
                      depth_out: $signed(depth_reg)};

`ifndef ASSERT_OFF
    a_zero_zd: assert property (@(posedge clk) disable iff (!rst_n)
        en && dv_reg && dzero_reg |=> mzero_reg == '1)
        else $error("zero difference did not zero all lanes");
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg[ROOT_W-1] |-> srem_reg[ROOT_W-1] <= SUM_W'({sroot_reg[ROOT_W-1], 1'b0}))
        else $error("square root remainder too large");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(rv_reg) && $stable(qv_reg[0]))
        else $error("pipeline moved while held");
`endif

endmodule

### hw/rtl/radial_linear_falloff_field.sv
// Throughput: one query per cycle when nothing stalls;
// 33-stage square root and 31-stage divider.
// A 4-entry queue separates the front end from the back end pipeline.
// Reset: asynchronous, active low; clears pipeline valids and the queue,
// sets zero_distance to 1.0 and all other configuration registers to zero.
module radial_linear_falloff_field
    import rlff_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  query_t           query,
    output logic             sample_valid,
    input  logic             sample_stall,
    output sample_t          sample,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     front_en, back_en, front_valid;
    request_t front_req, head;
    q_ctl_t   q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: 1'b0, center_x: '0, center_y: '0, center_z: '0,
                         zero_distance: ZD_RESET, gains: '0, depth: '0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:      cfg_reg.mode          <= cfg_data[0];
                REG_CENTER_X:  cfg_reg.center_x      <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y:  cfg_reg.center_y      <= cfg_data[COORD_W-1:0];
                REG_CENTER_Z:  cfg_reg.center_z      <= cfg_data[COORD_W-1:0];
                REG_ZERO_DIST: cfg_reg.zero_distance <= cfg_data[ZD_W-1:0];
                REG_GAINS_UV:
                begin
                    cfg_reg.gains[0] <= cfg_data[63:32];
                    cfg_reg.gains[1] <= cfg_data[31:0];
                end
                REG_GAINS_TS:
                begin
                    cfg_reg.gains[2] <= cfg_data[63:32];
                    cfg_reg.gains[3] <= cfg_data[31:0];
                end
                REG_GAIN_DYE:
                begin
                    cfg_reg.gains[4] <= cfg_data[63:32];
                    cfg_reg.depth    <= cfg_data[31:0];
                end
                default: ;
            endcase
        end
    end

    assign front_en    = !(front_valid && q_out.full);
    assign query_stall = !front_en;
    assign back_en     = !(sample_valid && sample_stall);

    assign q_in.push  = front_valid && front_en;
    assign q_in.pop   = back_en && !q_out.empty;
    assign q_in.empty = 1'b0;
    assign q_in.full  = 1'b0;

    rlff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .valid     (query_valid),
        .query     (query),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .request   (front_req)
    );

    rlff_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (q_in),
        .push_data (front_req),
        .ctl_out   (q_out),
        .head      (head)
    );

    rlff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (!q_out.empty),
        .request   (head),
        .cfg       (cfg_reg),
        .out_valid (sample_valid),
        .sample    (sample)
    );

endmodule

### tb/sv/radial_linear_falloff_field_test.sv
module radial_linear_falloff_field_test;
    import rlff_pkg::*;

    class falloff_board;
        logic             mode;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]      zd;
        logic [63:0]      guv, gts, gdd;
        sample_t          pending[$];
        int               errors;

        function void reset_regs();
            mode = 0; cx = 0; cy = 0; cz = 0; zd = 31'd65536;
            guv = 0; gts = 0; gdd = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] d);
            case (idx)
                REG_MODE:      mode = d[0];
                REG_CENTER_X:  cx = d[31:0];
                REG_CENTER_Y:  cy = d[31:0];
                REG_CENTER_Z:  cz = d[31:0];
                REG_ZERO_DIST: zd = d[30:0];
                REG_GAINS_UV:  guv = d;
                REG_GAINS_TS:  gts = d;
                REG_GAIN_DYE:  gdd = d;
                default: ;
            endcase
        endfunction

        function logic [30:0] falloff(logic [31:0] gbits, logic [63:0] distance);
            logic signed [63:0]  g, diff;
            logic [127:0]        p, q;
            g = $signed(gbits);
            diff = $signed({33'd0, zd}) - $signed(distance);
            if (zd == 0 || g == 0 || diff == 0 || ((g < 0) != (diff < 0)))
                return 0;
            p = 128'(g < 0 ? -g : g) * 128'(diff < 0 ? -diff : diff);
            q = p / zd;
            return q > 128'(OUT_MAX) ? OUT_MAX : q[30:0];
        endfunction

        function void note_query(query_t qr);
            logic [63:0]  ax, ay, az, distance, r, c;
            logic [127:0] s;
            sample_t      e;
            ax = $signed(qr.pos_x) - $signed(cx);
            ax = $signed(ax) < 0 ? -ax : ax;
            ay = $signed(qr.pos_y) - $signed(cy);
            ay = $signed(ay) < 0 ? -ay : ay;
            az = $signed(qr.pos_height) - $signed(cz);
            az = $signed(az) < 0 ? -az : az;
            if (mode == 0)
            begin
                s = 128'(ax) * ax + 128'(ay) * ay + 128'(az) * az;
                r = 0;
                for (int b = 63; b >= 0; b--)
                begin
                    c = r | (64'd1 << b);
                    if (128'(c) * c <= s)
                        r = c;
                end
                distance = r;
            end
            else
                distance = ax > ay ? ax : ay;
            e.vel_u = falloff(guv[63:32], distance);
            e.vel_v = falloff(guv[31:0], distance);
            e.temperature = falloff(gts[63:32], distance);
            e.salinity = falloff(gts[31:0], distance);
            e.dye_level = falloff(gdd[63:32], distance);
            e.depth_out = gdd[31:0];
            pending.push_back(e);
        endfunction

        function void check_sample(sample_t got);
            sample_t e;
            if (pending.size() == 0)
            begin
                report_error("sample with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (got.vel_u !== e.vel_u) report_error($sformatf("vel_u %h/%h", got.vel_u, e.vel_u));
            if (got.vel_v !== e.vel_v) report_error($sformatf("vel_v %h/%h", got.vel_v, e.vel_v));
            if (got.temperature !== e.temperature)
                report_error($sformatf("temperature %h/%h", got.temperature, e.temperature));
            if (got.salinity !== e.salinity)
                report_error($sformatf("salinity %h/%h", got.salinity, e.salinity));
            if (got.dye_level !== e.dye_level)
                report_error($sformatf("dye_level %h/%h", got.dye_level, e.dye_level));
            if (got.depth_out !== e.depth_out)
                report_error($sformatf("depth_out %h/%h", got.depth_out, e.depth_out));
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", msg);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             query_valid;
    logic             query_stall;
    query_t           query;
    logic             sample_valid;
    logic             sample_stall;
    sample_t          sample;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    falloff_board board;
    int           cycles;
    bit           hold_off;
    bit           stall_mode;

    radial_linear_falloff_field dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && sample_valid && !sample_stall)
            board.check_sample(sample);

    always @(posedge clk)
        if (rst_n && query_valid && !query_stall)
            board.note_query(query);

    // receiver stall pattern
    initial
    begin
        int run;
        sample_stall = 0;
        stall_mode = 0;
        forever
        begin
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                @(posedge clk);
                if (hold_off)
                    sample_stall <= 1;
                else if (stall_mode)
                    sample_stall <= ($urandom_range(0, 3) == 0);
                else
                    sample_stall <= 0;
            end
            stall_mode = ~stall_mode;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        query_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_query(query_t qr);
        query_valid <= 1;
        query <= qr;
        do @(posedge clk); while (query_stall);
    endtask

    logic [63:0] burst_left;

    task automatic send_paced(query_t qr);
        if (burst_left == 0)
        begin
            query_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        query_valid <= 1;
        query <= qr;
        do @(posedge clk); while (query_stall);
        burst_left--;
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed(32'($urandom_range(0, 20'hFFFFF))) - 32'sh80000;
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t qr;
        qr.pos_x = board.cx + rand_coord($urandom_range(0, 9) == 0 ? 0 : 2);
        qr.pos_y = board.cy + rand_coord($urandom_range(0, 9) == 0 ? 0 : 2);
        qr.pos_height = board.cz + rand_coord($urandom_range(0, 9) == 0 ? 1 : 2);
        if ($urandom_range(0, 19) == 0)
        begin
            qr.pos_x = rand_coord(1);
            qr.pos_y = rand_coord(0);
        end
        return qr;
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom;
            default: return $signed(32'($urandom_range(0, 32'h3FFFFF))) - 32'sh1FFFFF;
        endcase
    endfunction

    initial
    begin
        query_t qr;
        logic [30:0] zds[5];
        board = new();
        board.reset_regs();
        hold_off = 0;
        burst_left = 0;
        rst_n = 0;
        query_valid = 0;
        query = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // defaults: gains zero, then extremes of fields
        send_query('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        wait_idle();
        write_reg(REG_GAINS_UV, {32'h0001_0000, 32'hFFFF_0000});
        write_reg(REG_GAINS_TS, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_GAIN_DYE, {32'h0003_0000, 32'h8000_0001});
        send_query('{32'sh0, 32'sh0, 32'sh0});
        send_query('{32'sh8000, 32'sh0, 32'sh0});
        send_query('{32'sh10000, 32'sh0, 32'sh0});
        send_query('{32'sh0, 32'sh0, 32'sh20000});
        send_query('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_query('{32'shFFFF_FFFF, 32'sh1, 32'shFFFF_FFFF});
        wait_idle();
        write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_query('{32'sh3000, 32'shFFFF_9000, 32'sh7FFF_FFFF});
        send_query('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0});
        send_query('{32'sh1_0000, 32'sh0, 32'sh0});
        wait_idle();
        write_reg(REG_CENTER_X, 64'hFFFF_FFFF_8000_0000);
        write_reg(REG_CENTER_Y, 64'h7FFF_FFFF);
        write_reg(REG_CENTER_Z, 64'h8000_0000);
        write_reg(REG_ZERO_DIST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_query('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        send_query('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
        wait_idle();
        write_reg(REG_MODE, 0);
        send_query('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        send_query('{32'sh0, 32'sh0, 32'sh0});
        wait_idle();
        write_reg(REG_ZERO_DIST, 1);
        send_query('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
        send_query('{32'sh8000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000});
        wait_idle();
        write_reg(REG_ZERO_DIST, 0);
        send_query('{32'sh1234_5678, 32'sh0, 32'sh0});
        wait_idle();

        zds = '{31'd1, 31'd65536, 31'h7FFF_FFFF, 31'h40000, 31'd300};
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_MODE, $urandom_range(0, 1));
            write_reg(REG_CENTER_X, {$urandom, $urandom});
            write_reg(REG_CENTER_Y, {$urandom, $urandom});
            write_reg(REG_CENTER_Z, {$urandom, $urandom});
            write_reg(REG_ZERO_DIST, ph < 5 ? 64'(zds[ph]) :
                      64'($urandom_range(1, 32'h000F_FFFF)));
            write_reg(REG_GAINS_UV, {rand_gain(), rand_gain()});
            write_reg(REG_GAINS_TS, {rand_gain(), rand_gain()});
            write_reg(REG_GAIN_DYE, {rand_gain(), 32'($urandom)});
            if (ph == 3)
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int i = 0; i < 140; i++)
            begin
                qr = rand_query();
                send_paced(qr);
            end
            burst_left = 0;
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### filelist.f
hw/rtl/rlff_pkg.sv
hw/rtl/rlff_front.sv
hw/rtl/rlff_queue.sv
hw/rtl/rlff_back.sv
hw/rtl/radial_linear_falloff_field.sv
tb/sv/radial_linear_falloff_field_test.sv
